FILE: design/mqsb_pkg.sv
package mqsb_pkg;

   // Store geometry
   localparam int ENTRIES = 64;
   localparam int QUEUES  = 4;

   localparam int DATA_W = 32;
   localparam int QID_W  = 2;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int LNK_W  = $clog2(ENTRIES + 1);
   localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   // End of a list is coded as the entry count
   localparam logic [LNK_W-1:0] LIST_END = LNK_W'(ENTRIES);

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Classified command from the front to the back
   typedef struct packed {
      logic              is_pop;
      logic              q_ok;
      logic [QSEL_W-1:0] qsel;
      logic [DATA_W-1:0] value;
   } cmd_type;

   typedef enum logic {
      BK_ISSUE,
      BK_FINISH
   } bk_state_type;

   // Any link outside the store reads as the end marker
   function automatic logic [LNK_W-1:0] clean_link(logic [LNK_W-1:0] v);
      return (int'(v) < ENTRIES) ? v : LIST_END;
   endfunction

endpackage

FILE: design/multi_queue_shared_buffer.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  req_operation, req_queue_id, req_value
// rsp       rsp_valid / rsp_stall  rsp_status, rsp_popped_value
//
// In the back engine each beat runs an issue step that reads the link and data
// memories (registered read), then a finish step that writes the link memory
// and posts the result. A two-deep command queue lets req beats land while
// the engine works or a result waits. Reset is synchronous; it empties all queues
// and rebuilds the free list through per-entry link valid bits, with no clearing pass.
// rsp_stall holds the result register and the engine in its finish step.
module multi_queue_shared_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [mqsb_pkg::QID_W-1:0]  req_queue_id,
   input  logic signed [mqsb_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic signed [mqsb_pkg::DATA_W-1:0] rsp_popped_value
);

   logic              cmd_valid;
   logic              cmd_take;
   mqsb_pkg::cmd_type cmd;

   // Accept and classify
   mqsb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_queue_id  (req_queue_id),
      .req_value     (req_value),
      .cmd_valid     (cmd_valid),
      .cmd_take      (cmd_take),
      .cmd           (cmd)
   );

   // List engine and result register
   mqsb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value)
   );

endmodule

FILE: design/mqsb_front.sv
module mqsb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [mqsb_pkg::QID_W-1:0]  req_queue_id,
   input  logic signed [mqsb_pkg::DATA_W-1:0] req_value,
   output logic                        cmd_valid,
   input  logic                        cmd_take,
   output mqsb_pkg::cmd_type           cmd
);

   // Two-deep command queue between front and back
   mqsb_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   mqsb_pkg::cmd_type cls;
   logic              push;
   logic              pop;

   // Classify the incoming beat
   always_comb begin
      cls.is_pop = (req_operation == mqsb_pkg::OP_POP);
      cls.q_ok   = (int'(req_queue_id) < mqsb_pkg::QUEUES);
      cls.qsel   = mqsb_pkg::QSEL_W'(req_queue_id);
      cls.value  = req_value;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_take && cmd_valid;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: design/mqsb_back.sv
module mqsb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  mqsb_pkg::cmd_type           cmd,
   output logic                        cmd_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic signed [mqsb_pkg::DATA_W-1:0] rsp_popped_value
);

   localparam int ENT    = mqsb_pkg::ENTRIES;
   localparam int QN     = mqsb_pkg::QUEUES;
   localparam int IDX_W  = mqsb_pkg::IDX_W;
   localparam int LNK_W  = mqsb_pkg::LNK_W;
   localparam int QSEL_W = mqsb_pkg::QSEL_W;
   localparam int DATA_W = mqsb_pkg::DATA_W;

   mqsb_pkg::bk_state_type state_ff, state_in;

   // Entry store
   logic [LNK_W-1:0]  link_mem [ENT];
   logic [DATA_W-1:0] data_mem [ENT];
   logic              lk_vld_ff [ENT];

   logic [LNK_W-1:0]  lk_rd_ff;
   logic              lk_rd_vld_ff;
   logic [IDX_W-1:0]  lk_ra_ff;
   logic [DATA_W-1:0] dt_rd_ff;

   // List pointers
   logic [LNK_W-1:0] qhead_ff [QN];
   logic [IDX_W-1:0] qtail_ff [QN];
   logic [LNK_W-1:0] free_head_ff, free_head_in;

   // Operation in flight
   logic              op_pop_ff, op_pop_in;
   logic              op_ok_ff, op_ok_in;
   logic [QSEL_W-1:0] op_qsel_ff, op_qsel_in;
   logic [IDX_W-1:0]  op_idx_ff, op_idx_in;

   // Result register
   logic              out_vld_ff, out_vld_in;
   logic [1:0]        out_status_ff, out_status_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;

   // Memory and pointer write controls
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              lk_we;
   logic [IDX_W-1:0]  lk_wa;
   logic [LNK_W-1:0]  lk_wd;
   logic              dt_we;
   logic              qh_we;
   logic [LNK_W-1:0]  qh_wd;
   logic [QSEL_W-1:0] qh_wa;
   logic              qt_we;

   logic [LNK_W-1:0] q_head;
   logic [IDX_W-1:0] q_tail;
   logic [LNK_W-1:0] pop_head;
   logic             push_ok;
   logic             pop_ok;
   logic [LNK_W-1:0] link_eff;

   // Addressed queue and link read result (untouched entries chain to next)
   assign q_head   = cmd.q_ok ? qhead_ff[cmd.qsel] : mqsb_pkg::LIST_END;
   assign q_tail   = qtail_ff[cmd.qsel];
   assign pop_head = q_head;
   assign push_ok  = !cmd.is_pop && cmd.q_ok && (free_head_ff != mqsb_pkg::LIST_END);
   assign pop_ok   = cmd.is_pop && (pop_head != mqsb_pkg::LIST_END);
   assign link_eff = lk_rd_vld_ff ? lk_rd_ff : (LNK_W'(lk_ra_ff) + LNK_W'(1));

   // Sequencer: issue reads and tail link, then finish and post result
   always_comb begin
      state_in      = state_ff;
      cmd_take      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cmd.is_pop ? pop_head[IDX_W-1:0] : free_head_ff[IDX_W-1:0];
      lk_we         = 1'b0;
      lk_wa         = q_tail;
      lk_wd         = free_head_ff;
      dt_we         = 1'b0;
      qh_we         = 1'b0;
      qh_wa         = cmd.qsel;
      qh_wd         = free_head_ff;
      qt_we         = 1'b0;
      free_head_in  = free_head_ff;
      op_pop_in     = op_pop_ff;
      op_ok_in      = op_ok_ff;
      op_qsel_in    = op_qsel_ff;
      op_idx_in     = op_idx_ff;
      out_vld_in    = out_vld_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      unique case (state_ff)
         mqsb_pkg::BK_ISSUE: begin
            if (cmd_valid) begin
               cmd_take   = 1'b1;
               rd_en      = push_ok || pop_ok;
               op_pop_in  = cmd.is_pop;
               op_ok_in   = push_ok || pop_ok;
               op_qsel_in = cmd.qsel;
               op_idx_in  = rd_addr;
               if (push_ok) begin
                  dt_we = 1'b1;
                  qt_we = 1'b1;
                  if (q_head == mqsb_pkg::LIST_END) begin
                     qh_we = 1'b1;
                  end else if (int'(q_tail) < ENT) begin
                     lk_we = 1'b1;
                  end
               end
               state_in = mqsb_pkg::BK_FINISH;
            end
         end
         mqsb_pkg::BK_FINISH: begin
            if (!out_vld_ff || !rsp_stall) begin
               lk_wa = op_idx_ff;
               qh_wa = op_qsel_ff;
               if (op_ok_ff) begin
                  lk_we = 1'b1;
                  if (op_pop_ff) begin
                     qh_we        = 1'b1;
                     qh_wd        = mqsb_pkg::clean_link(link_eff);
                     lk_wd        = free_head_ff;
                     free_head_in = LNK_W'(op_idx_ff);
                  end else begin
                     lk_wd        = mqsb_pkg::LIST_END;
                     free_head_in = mqsb_pkg::clean_link(link_eff);
                  end
               end
               out_vld_in = 1'b1;
               if (op_ok_ff) begin
                  out_status_in = mqsb_pkg::ST_DONE;
               end else if (op_pop_ff) begin
                  out_status_in = mqsb_pkg::ST_EMPTY;
               end else begin
                  out_status_in = mqsb_pkg::ST_FULL;
               end
               out_value_in = (op_ok_ff && op_pop_ff) ? dt_rd_ff : '0;
               state_in     = mqsb_pkg::BK_ISSUE;
            end
         end
         default: state_in = mqsb_pkg::BK_ISSUE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mqsb_pkg::BK_ISSUE;
         free_head_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // Queue heads start empty
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QN; i++) begin
            qhead_ff[i] <= mqsb_pkg::LIST_END;
         end
      end else if (qh_we) begin
         qhead_ff[qh_wa] <= qh_wd;
      end
   end

   // Link valid bits: a clear bit reads as the reset chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENT; i++) begin
            lk_vld_ff[i] <= 1'b0;
         end
      end else if (lk_we) begin
         lk_vld_ff[lk_wa] <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_pop_ff     <= op_pop_in;
      op_ok_ff      <= op_ok_in;
      op_qsel_ff    <= op_qsel_in;
      op_idx_ff     <= op_idx_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      if (qt_we) begin
         qtail_ff[cmd.qsel] <= rd_addr;
      end
   end

   // Link memory, registered read
   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_wa] <= lk_wd;
      end
      if (rd_en) begin
         lk_rd_ff     <= link_mem[rd_addr];
         lk_rd_vld_ff <= lk_vld_ff[rd_addr];
         lk_ra_ff     <= rd_addr;
      end
   end

   // Data memory, registered read
   always_ff @(posedge clock) begin
      if (dt_we) begin
         data_mem[rd_addr] <= cmd.value;
      end
      if (rd_en) begin
         dt_rd_ff <= data_mem[rd_addr];
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_popped_value = out_value_ff;

endmodule

FILE: tb/tb_top.sv
module tb_top;

   localparam int TOTAL_OPS   = 1350;
   localparam int CALM_TAIL   = 200;
   localparam int CYCLE_LIMIT = 250000;

   typedef struct {
      logic                              op;
      logic [mqsb_pkg::QID_W-1:0]        qid;
      logic [mqsb_pkg::DATA_W-1:0]       value;
      bit                                drain_first;
   } queue_op_type;

   typedef struct {
      logic [1:0]                        status;
      logic [mqsb_pkg::DATA_W-1:0]       popped;
   } queue_answer_type;

   // DUT inputs, all known from time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_operation = mqsb_pkg::OP_PUSH;
   logic [mqsb_pkg::QID_W-1:0]         req_queue_id = '0;
   logic signed [mqsb_pkg::DATA_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_status;
   logic signed [mqsb_pkg::DATA_W-1:0] rsp_popped_value;

   multi_queue_shared_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_queue_id     (req_queue_id),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow of the shared store: data, links, per-queue head/tail, free list
   logic [mqsb_pkg::DATA_W-1:0] store_data [mqsb_pkg::ENTRIES];
   logic [mqsb_pkg::LNK_W-1:0]  store_link [mqsb_pkg::ENTRIES];
   logic [mqsb_pkg::LNK_W-1:0]  q_head     [mqsb_pkg::QUEUES];
   logic [mqsb_pkg::IDX_W-1:0]  q_tail     [mqsb_pkg::QUEUES];
   logic [mqsb_pkg::LNK_W-1:0]  free_ptr;

   queue_op_type     op_backlog[$];
   queue_answer_type queue_answers[$];
   queue_op_type     beat_on_wire;
   int               send_gap  = 0;
   int               stall_gap = 0;
   int               errors    = 0;
   int               cycle_count = 0;

   function automatic void clear_store();
      for (int i = 0; i < mqsb_pkg::ENTRIES; i++) begin
         store_data[i] = '0;
         store_link[i] = mqsb_pkg::LNK_W'(i + 1);
      end
      for (int q = 0; q < mqsb_pkg::QUEUES; q++) begin
         q_head[q] = mqsb_pkg::LIST_END;
         q_tail[q] = '0;
      end
      free_ptr = '0;
   endfunction

   // Apply one push/pop to the shadow store and queue up its answer
   function automatic void apply_queue_op(queue_op_type b);
      queue_answer_type           a;
      logic [mqsb_pkg::LNK_W-1:0] slot;
      logic [mqsb_pkg::LNK_W-1:0] first;
      a.status = mqsb_pkg::ST_DONE;
      a.popped = '0;
      if (b.op == mqsb_pkg::OP_PUSH) begin
         slot = free_ptr;
         if (int'(b.qid) >= mqsb_pkg::QUEUES || slot == mqsb_pkg::LIST_END) begin
            a.status = mqsb_pkg::ST_FULL;
         end else begin
            first = q_head[b.qid];
            store_data[slot[mqsb_pkg::IDX_W-1:0]] = b.value;
            if (first == mqsb_pkg::LIST_END) begin
               q_head[b.qid] = slot;
            end else begin
               store_link[q_tail[b.qid]] = slot;
            end
            q_tail[b.qid] = slot[mqsb_pkg::IDX_W-1:0];
            free_ptr = store_link[slot[mqsb_pkg::IDX_W-1:0]];
            store_link[slot[mqsb_pkg::IDX_W-1:0]] = mqsb_pkg::LIST_END;
         end
      end else begin
         first = (int'(b.qid) < mqsb_pkg::QUEUES) ? q_head[b.qid] : mqsb_pkg::LIST_END;
         if (first == mqsb_pkg::LIST_END) begin
            a.status = mqsb_pkg::ST_EMPTY;
         end else begin
            a.popped = store_data[first[mqsb_pkg::IDX_W-1:0]];
            q_head[b.qid] = store_link[first[mqsb_pkg::IDX_W-1:0]];
            store_link[first[mqsb_pkg::IDX_W-1:0]] = free_ptr;
            free_ptr = first;
         end
      end
      queue_answers.push_back(a);
   endfunction

   function automatic void add_op(logic op, int qid, logic [mqsb_pkg::DATA_W-1:0] value,
                                  bit drain_first);
      queue_op_type b;
      b.op          = op;
      b.qid         = mqsb_pkg::QID_W'(qid);
      b.value       = value;
      b.drain_first = drain_first;
      op_backlog.push_back(b);
   endfunction

   // Request driver: new beat only when the wire is free
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_queue_op(beat_on_wire);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (op_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (op_backlog[0].drain_first && queue_answers.size() > 0) begin
               // hold off until the block has answered everything
               req_valid <= 1'b0;
            end else if (op_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else begin
               beat_on_wire = op_backlog.pop_front();
               req_valid     <= 1'b1;
               req_operation <= beat_on_wire.op;
               req_queue_id  <= beat_on_wire.qid;
               req_value     <= beat_on_wire.value;
            end
         end
      end
   end

   // Result monitor with random stall bursts
   always @(posedge clock) begin
      queue_answer_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (queue_answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, status %0d popped %0d",
                        $time, rsp_status, rsp_popped_value);
            end else begin
               e = queue_answers.pop_front();
               if (rsp_status !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, e.status, rsp_status);
               end
               if (rsp_popped_value !== e.popped) begin
                  errors++;
                  $display("%0t: popped_value expected %0d actual %0d",
                           $time, $signed(e.popped), rsp_popped_value);
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (op_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int                          phase_len;
      int                          push_pct;
      int                          qid;
      logic [mqsb_pkg::DATA_W-1:0] v;

      clear_store();

      // Directed: empty pops, extreme values, FIFO order, pop ignores value
      for (int q = 0; q < mqsb_pkg::QUEUES; q++)
         add_op(mqsb_pkg::OP_POP, q, 32'hFFFF_FFFF, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 0, 32'h8000_0000, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 0, 32'h7FFF_FFFF, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 1, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 2, 32'hFFFF_FFFF, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 3, 32'h5555_5555, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 3, 32'hAAAA_AAAA, 1'b0);
      add_op(mqsb_pkg::OP_POP,  0, 32'h1234_5678, 1'b1);
      add_op(mqsb_pkg::OP_POP,  0, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_POP,  0, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_POP,  3, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_PUSH, 3, 32'h0000_0001, 1'b0);
      add_op(mqsb_pkg::OP_POP,  3, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_POP,  3, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_POP,  1, 32'hDEAD_BEEF, 1'b0);
      add_op(mqsb_pkg::OP_POP,  2, 32'h0000_0000, 1'b0);
      add_op(mqsb_pkg::OP_POP,  2, 32'h0000_0000, 1'b0);

      // Random: phases that fill toward full, drain toward empty, or mix
      while (op_backlog.size() < TOTAL_OPS) begin
         phase_len = $urandom_range(20, 130);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         for (int i = 0; i < phase_len && op_backlog.size() < TOTAL_OPS; i++) begin
            case ($urandom_range(0, 15))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = $urandom;
            endcase
            qid = $urandom_range(0, mqsb_pkg::QUEUES - 1);
            add_op(($urandom_range(0, 99) < push_pct) ? mqsb_pkg::OP_PUSH : mqsb_pkg::OP_POP,
                   qid, v, (op_backlog.size() % 300) == 299);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() > 0 || req_valid) @(posedge clock);
      while (queue_answers.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/mqsb_pkg.sv
design/mqsb_front.sv
design/mqsb_back.sv
design/multi_queue_shared_buffer.sv
tb/tb_top.sv
